>>> design/indexed_linked_list_engine_top_defines.svh
// assertion macros for the list engine
`ifndef INDEXED_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_LINKED_LIST_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define ILLE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ILLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ille_pkg.sv
`default_nettype none

package ille_pkg;

   localparam int WORD_W       = 32;
   localparam int CMD_W        = 3;
   localparam int POS_W        = 9;
   localparam int ENT_W        = 9;
   localparam int CMP_W        = 17;
   localparam int DEF_CAPACITY = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_READ   = 3'd1,
      CMD_WRITE  = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_REMOVE = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      OP_HOLD   = 3'd0,
      OP_ROTATE = 3'd1,
      OP_INSERT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_WRITE  = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [CMP_W-1:0]         pos;
      logic signed [WORD_W-1:0] data;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> design/ille_if.sv
`default_nettype none

interface ille_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ille_pkg::CMD_W-1:0]           cmd;
   logic [ille_pkg::POS_W-1:0]           position;
   logic signed [ille_pkg::WORD_W-1:0]   word_in;

   modport source (output valid, output cmd, output position, output word_in, input ready);
   modport sink   (input valid, input cmd, input position, input word_in, output ready);
endinterface

interface ille_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 ok;
   logic signed [ille_pkg::WORD_W-1:0]   word_out;
   logic [ille_pkg::ENT_W-1:0]           entries;

   modport source (output valid, output ok, output word_out, output entries, input ready);
   modport sink   (input valid, input ok, input word_out, input entries, output ready);
endinterface

`default_nettype wire

>>> design/ille_cell.sv
`default_nettype none

module ille_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                               clock,
   input  wire ille_pkg::cell_ctl_type             ctl,
   input  wire logic signed [ille_pkg::WORD_W-1:0] left_word,
   input  wire logic signed [ille_pkg::WORD_W-1:0] right_word,
   output logic signed [ille_pkg::WORD_W-1:0]      held_word
);

   localparam int CmpW = ille_pkg::CMP_W;
   localparam logic [CmpW-1:0] MyIdx = CmpW'(INDEX);

   logic signed [ille_pkg::WORD_W-1:0] word_ff;
   logic signed [ille_pkg::WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      case (ctl.op)
         ille_pkg::OP_ROTATE: begin
            word_in = right_word;
         end
         ille_pkg::OP_INSERT: begin
            if (ctl.pos < MyIdx) begin
               word_in = left_word;
            end else if (ctl.pos == MyIdx) begin
               word_in = ctl.data;
            end
         end
         ille_pkg::OP_REMOVE: begin
            if (ctl.pos <= MyIdx) begin
               word_in = right_word;
            end
         end
         ille_pkg::OP_WRITE: begin
            if (ctl.pos == MyIdx) begin
               word_in = ctl.data;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign held_word = word_ff;

endmodule

`default_nettype wire

>>> design/ille_chain.sv
`default_nettype none

module ille_chain #(
   parameter int CAPACITY = ille_pkg::DEF_CAPACITY
) (
   input  wire logic                           clock,
   input  wire ille_pkg::cell_ctl_type         ctl,
   output logic signed [ille_pkg::WORD_W-1:0]  head_word
);

   logic signed [ille_pkg::WORD_W-1:0] cell_word [CAPACITY];

   // ring of cells, list position i lives in cell i
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ille_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_word  (cell_word[(i + CAPACITY - 1) % CAPACITY]),
         .right_word (cell_word[(i + 1) % CAPACITY]),
         .held_word  (cell_word[i])
      );
   end

   assign head_word = cell_word[0];

endmodule

`default_nettype wire

>>> design/indexed_linked_list_engine_top.sv
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells,
// list position i in cell i. Append, insert, overwrite, clear and every
// failing command give their result in the cycle after the request is taken.
// Read and remove first sweep the ring of cells, which rotates one cell
// per cycle past cell 0 through a full turn to fetch the word and restore
// the order, and remove closes the gap in the cycle that the result is
// registered. A new request is taken when the engine is idle and the
// result register is empty or being emptied in the same cycle.
`default_nettype none

`include "indexed_linked_list_engine_top_defines.svh"

module indexed_linked_list_engine_top #(
   parameter int CAPACITY = ille_pkg::DEF_CAPACITY
) (
   input wire logic    clock,
   input wire logic    reset,
   ille_req_if.sink    req_port,
   ille_rsp_if.source  rsp_port
);

   localparam int CmpW = ille_pkg::CMP_W;
   localparam int WordW = ille_pkg::WORD_W;
   localparam int EntW = ille_pkg::ENT_W;
   localparam int IdxW = $clog2(CAPACITY);
   localparam int CntW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [IdxW-1:0]          step_ff, step_in;
   logic [CmpW-1:0]          pos_ff, pos_in;
   logic                     rm_ff, rm_in;
   logic signed [WordW-1:0]  capt_ff, capt_in;
   logic [CntW-1:0]          count_ff, count_in;

   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff;
   logic signed [WordW-1:0]  rsp_word_ff;
   logic [EntW-1:0]          rsp_entries_ff;

   logic                     rsp_load;
   logic                     rsp_ok_in;
   logic signed [WordW-1:0]  rsp_word_in;
   logic                     rsp_free;
   logic                     req_ready;
   logic                     accept;
   logic                     full;
   logic [CmpW-1:0]          req_pos;
   logic [CmpW-1:0]          count_pos;
   logic                     pos_lt;
   logic                     pos_le;

   ille_pkg::cell_ctl_type   ctl;
   logic signed [WordW-1:0]  head_word;

   ille_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .head_word (head_word)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_port.ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept    = req_port.valid && req_ready;
   assign full      = (count_ff == CntW'(CAPACITY));
   assign req_pos   = CmpW'(req_port.position);
   assign count_pos = CmpW'(count_ff);
   assign pos_lt    = (req_pos < count_pos);
   assign pos_le    = (req_pos <= count_pos);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      pos_in      = pos_ff;
      rm_in       = rm_ff;
      capt_in     = capt_ff;
      count_in    = count_ff;
      ctl.op      = ille_pkg::OP_HOLD;
      ctl.pos     = '0;
      ctl.data    = req_port.word_in;
      rsp_load    = 1'b0;
      rsp_ok_in   = 1'b0;
      rsp_word_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (req_port.cmd)
                  ille_pkg::CMD_APPEND: begin
                     if (!full) begin
                        ctl.op    = ille_pkg::OP_INSERT;
                        ctl.pos   = count_pos;
                        count_in  = count_ff + 1'b1;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  ille_pkg::CMD_READ, ille_pkg::CMD_REMOVE: begin
                     if (pos_lt) begin
                        rsp_load = 1'b0;
                        state_in = ST_SWEEP;
                        step_in  = '0;
                        pos_in   = req_pos;
                        rm_in    = (req_port.cmd == ille_pkg::CMD_REMOVE);
                     end
                  end
                  ille_pkg::CMD_WRITE: begin
                     if (pos_lt) begin
                        ctl.op    = ille_pkg::OP_WRITE;
                        ctl.pos   = req_pos;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  ille_pkg::CMD_INSERT: begin
                     if (pos_le && !full) begin
                        ctl.op    = ille_pkg::OP_INSERT;
                        ctl.pos   = req_pos;
                        count_in  = count_ff + 1'b1;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  ille_pkg::CMD_CLEAR: begin
                     count_in  = '0;
                     rsp_ok_in = 1'b1;
                  end
                  default: begin
                     rsp_ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // full turn of the ring, cell 0 shows position step
            ctl.op = ille_pkg::OP_ROTATE;
            if (CmpW'(step_ff) == pos_ff) begin
               capt_in = head_word;
            end
            step_in = IdxW'(step_ff + 1'b1);
            if (step_ff == IdxW'(CAPACITY - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_ok_in   = 1'b1;
               rsp_word_in = capt_ff;
               if (rm_ff) begin
                  ctl.op   = ille_pkg::OP_REMOVE;
                  ctl.pos  = pos_ff;
                  count_in = count_ff - 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      pos_ff  <= pos_in;
      rm_ff   <= rm_in;
      capt_ff <= capt_in;
      if (rsp_load) begin
         rsp_ok_ff      <= rsp_ok_in;
         rsp_word_ff    <= rsp_word_in;
         rsp_entries_ff <= EntW'(count_in);
      end
   end

   assign req_port.ready    = req_ready;
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.ok       = rsp_ok_ff;
   assign rsp_port.word_out = rsp_word_ff;
   assign rsp_port.entries  = rsp_entries_ff;

   `ILLE_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CntW'(CAPACITY), "entry count beyond capacity")
   `ILLE_ASSERT_NOW(a_accept_idle, clock, reset, accept, state_ff == ST_IDLE, "request taken while busy")
   `ILLE_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_word_ff == '0, "failed request carries a word")
   `ILLE_ASSERT_NEXT(a_sweep_end, clock, reset, state_ff == ST_SWEEP && step_ff == IdxW'(CAPACITY - 1), state_ff == ST_DONE, "ring turn did not finish")
   `ILLE_ASSERT_NEXT(a_fail_keep, clock, reset, rsp_load && !rsp_ok_in, $stable(count_ff), "failed request changed the count")

endmodule

`default_nettype wire

>>> dv/indexed_linked_list_engine_top_tb.sv
module indexed_linked_list_engine_top_tb;

   localparam int LIST_CAP      = ille_pkg::DEF_CAPACITY;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int DRAIN_CYCLES  = 300;

   localparam logic [ille_pkg::CMD_W-1:0] UNDEF_CMD_LO = 3'd6;
   localparam logic [ille_pkg::CMD_W-1:0] UNDEF_CMD_HI = 3'd7;

   typedef struct {
      logic [ille_pkg::CMD_W-1:0]         cmd;
      logic [ille_pkg::POS_W-1:0]         pos;
      logic signed [ille_pkg::WORD_W-1:0] word;
      int                                 gap;
   } list_req_type;

   typedef struct packed {
      logic                               ok;
      logic signed [ille_pkg::WORD_W-1:0] word;
      logic [ille_pkg::ENT_W-1:0]         entries;
   } list_rsp_type;

   logic clock;
   logic reset;

   ille_req_if req_if ();
   ille_rsp_if rsp_if ();

   indexed_linked_list_engine_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   list_req_type                       req_queue[$];
   list_rsp_type                       expected_rsps[$];
   logic signed [ille_pkg::WORD_W-1:0] list_words[$];

   int gen_count;
   bit gen_burst;
   int total_reqs;
   int reqs_taken;
   int fail_count;
   int idle_cycles;
   int req_gap;
   int next_gap;
   int rsp_stall;
   int rsps_seen;
   bit rsp_burst;
   bit req_taken;
   bit rsp_taken;

   always #10 clock = ~clock;

   // list behaviour at the level of positions
   function automatic list_rsp_type apply_list_cmd(logic [ille_pkg::CMD_W-1:0] c,
                                                   logic [ille_pkg::POS_W-1:0] p,
                                                   logic signed [ille_pkg::WORD_W-1:0] w);
      list_rsp_type r;
      int           n;
      r = '0;
      n = list_words.size();
      if (c == ille_pkg::CMD_INSERT && p == n) c = ille_pkg::CMD_APPEND;
      case (c)
         ille_pkg::CMD_APPEND: begin
            if (n < LIST_CAP) begin
               list_words.push_back(w);
               r.ok = 1'b1;
            end
         end
         ille_pkg::CMD_READ: begin
            if (p < n) begin
               r.word = list_words[p];
               r.ok   = 1'b1;
            end
         end
         ille_pkg::CMD_WRITE: begin
            if (p < n) begin
               list_words[p] = w;
               r.ok = 1'b1;
            end
         end
         ille_pkg::CMD_INSERT: begin
            if (p < n && n < LIST_CAP) begin
               list_words.insert(p, w);
               r.ok = 1'b1;
            end
         end
         ille_pkg::CMD_REMOVE: begin
            if (p < n) begin
               r.word = list_words[p];
               list_words.delete(p);
               r.ok = 1'b1;
            end
         end
         ille_pkg::CMD_CLEAR: begin
            list_words.delete();
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.entries = ille_pkg::ENT_W'(list_words.size());
      return r;
   endfunction

   // queue a request and track the entry count it leaves behind
   task automatic add_req(logic [ille_pkg::CMD_W-1:0] c, int p,
                          logic signed [ille_pkg::WORD_W-1:0] w);
      list_req_type it;
      logic [ille_pkg::CMD_W-1:0] ec;
      ec = c;
      it.cmd  = c;
      it.pos  = p[ille_pkg::POS_W-1:0];
      it.word = w;
      it.gap  = gen_burst ? 0 : $urandom_range(0, 5);
      req_queue.push_back(it);
      if (ec == ille_pkg::CMD_INSERT && it.pos == gen_count) ec = ille_pkg::CMD_APPEND;
      case (ec)
         ille_pkg::CMD_APPEND: if (gen_count < LIST_CAP) gen_count++;
         ille_pkg::CMD_INSERT: if (it.pos < gen_count && gen_count < LIST_CAP) gen_count++;
         ille_pkg::CMD_REMOVE: if (it.pos < gen_count) gen_count--;
         ille_pkg::CMD_CLEAR:  gen_count = 0;
         default: ;
      endcase
   endtask

   function automatic logic signed [ille_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_pos();
      return (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
         next_gap = 0;
      end else begin
         if (req_taken) req_gap = next_gap;
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap--;
         end else if (!req_if.valid || req_taken) begin
            if (req_queue.size() > 0) begin
               list_req_type it;
               it = req_queue.pop_front();
               req_if.cmd      <= it.cmd;
               req_if.position <= it.pos;
               req_if.word_in  <= it.word;
               req_if.valid    <= 1'b1;
               next_gap = it.gap;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result ready with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
         rsps_seen = 0;
         rsp_burst = 1'b0;
      end else begin
         if (rsp_taken) begin
            rsps_seen++;
            if (rsps_seen % 64 == 0) rsp_burst = $urandom_range(0, 1);
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 5);
         end
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      req_taken <= !reset && req_if.valid && req_if.ready;
      rsp_taken <= !reset && rsp_if.valid && rsp_if.ready;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_if.valid && req_if.ready) begin
            expected_rsps.push_back(apply_list_cmd(req_if.cmd, req_if.position,
                                                   req_if.word_in));
            reqs_taken <= reqs_taken + 1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result ok %0b word %0d entries %0d", $time,
                        rsp_if.ok, rsp_if.word_out, rsp_if.entries);
               fail_count++;
            end else begin
               list_rsp_type exp_r;
               exp_r = expected_rsps.pop_front();
               if (rsp_if.ok !== exp_r.ok || rsp_if.word_out !== exp_r.word ||
                   rsp_if.entries !== exp_r.entries) begin
                  $display({"%0t: mismatch, expected ok %0b word %0d entries %0d,",
                            " actual ok %0b word %0d entries %0d"},
                           $time, exp_r.ok, exp_r.word, exp_r.entries,
                           rsp_if.ok, rsp_if.word_out, rsp_if.entries);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      int  sel;
      int  grow_lim;
      int  ins_lim;
      bit  shrink;

      clock           = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.cmd      = '0;
      req_if.position = '0;
      req_if.word_in  = '0;
      rsp_if.ready    = 1'b0;
      req_taken       = 1'b0;
      rsp_taken       = 1'b0;
      reqs_taken      = 0;
      fail_count      = 0;
      idle_cycles     = 0;
      gen_count       = 0;
      gen_burst       = 1'b0;
      shrink          = 1'b0;

      // directed: empty list cases, extremes, every command
      add_req(ille_pkg::CMD_CLEAR, 0, '0);
      add_req(ille_pkg::CMD_READ, 0, '0);
      add_req(ille_pkg::CMD_REMOVE, 0, '0);
      add_req(ille_pkg::CMD_INSERT, 1, 32'sd5);
      add_req(ille_pkg::CMD_INSERT, 0, 32'sh7fff_ffff);
      add_req(ille_pkg::CMD_APPEND, 0, 32'sh8000_0000);
      add_req(ille_pkg::CMD_APPEND, 0, '1);
      add_req(ille_pkg::CMD_INSERT, 0, 32'sd17);
      add_req(ille_pkg::CMD_INSERT, 2, 32'sh5555_aaaa);
      add_req(ille_pkg::CMD_READ, 0, '0);
      add_req(ille_pkg::CMD_READ, gen_count - 1, '0);
      add_req(ille_pkg::CMD_WRITE, 1, 32'shaaaa_5555);
      add_req(ille_pkg::CMD_READ, 1, '0);
      add_req(ille_pkg::CMD_REMOVE, gen_count - 1, '0);
      add_req(ille_pkg::CMD_APPEND, 0, 32'sd99);
      add_req(ille_pkg::CMD_READ, gen_count - 1, '0);
      add_req(ille_pkg::CMD_REMOVE, 0, '0);
      add_req(ille_pkg::CMD_REMOVE, 1, '0);
      add_req(ille_pkg::CMD_READ, 511, '0);
      add_req(ille_pkg::CMD_WRITE, 256, 32'sd1);
      add_req(ille_pkg::CMD_INSERT, 300, 32'sd1);
      add_req(UNDEF_CMD_LO, 0, '1);
      add_req(UNDEF_CMD_HI, 511, '1);
      add_req(ille_pkg::CMD_CLEAR, 0, '0);
      add_req(ille_pkg::CMD_READ, 0, '0);

      // fill the store and push against the full limit
      while (gen_count < LIST_CAP) begin
         if (($urandom_range(0, 3) == 0) && gen_count > 0)
            add_req(ille_pkg::CMD_INSERT, $urandom_range(0, gen_count), pick_word());
         else
            add_req(ille_pkg::CMD_APPEND, 0, pick_word());
      end
      add_req(ille_pkg::CMD_APPEND, 0, pick_word());
      add_req(ille_pkg::CMD_INSERT, 0, pick_word());
      add_req(ille_pkg::CMD_INSERT, LIST_CAP, pick_word());
      add_req(ille_pkg::CMD_READ, LIST_CAP - 1, '0);
      add_req(ille_pkg::CMD_REMOVE, LIST_CAP - 1, '0);
      add_req(ille_pkg::CMD_REMOVE, 0, '0);
      add_req(ille_pkg::CMD_INSERT, 100, pick_word());
      add_req(ille_pkg::CMD_APPEND, 0, pick_word());
      add_req(ille_pkg::CMD_READ, 100, '0);
      add_req(ille_pkg::CMD_CLEAR, 0, '0);

      // mixed random traffic
      while (req_queue.size() < RANDOM_ITEMS) begin
         if (req_queue.size() % 64 == 0) begin
            gen_burst = ($urandom_range(0, 3) == 0);
            shrink    = ($urandom_range(0, 2) == 0);
         end
         grow_lim = shrink ? 10 : 25;
         ins_lim  = shrink ? 20 : 45;
         sel = $urandom_range(0, 99);
         if (sel < grow_lim)
            add_req(ille_pkg::CMD_APPEND, $urandom_range(0, 511), pick_word());
         else if (sel < ins_lim)
            add_req(ille_pkg::CMD_INSERT, $urandom_range(0, gen_count), pick_word());
         else if (sel < 58)
            add_req(ille_pkg::CMD_READ, pick_pos(), $urandom);
         else if (sel < 71)
            add_req(ille_pkg::CMD_WRITE, pick_pos(), pick_word());
         else if (sel < 86)
            add_req(ille_pkg::CMD_REMOVE, pick_pos(), $urandom);
         else if (sel < 88)
            add_req(ille_pkg::CMD_CLEAR, $urandom_range(0, 511), $urandom);
         else
            add_req(ille_pkg::CMD_W'($urandom_range(0, 7)), $urandom_range(0, 511),
                    pick_word());
      end
      total_reqs = req_queue.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (!(reqs_taken == total_reqs && expected_rsps.size() == 0)) begin
         @(negedge clock);
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Some tests failed");
            $finish;
         end
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/ille_pkg.sv
design/ille_if.sv
design/ille_cell.sv
design/ille_chain.sv
design/indexed_linked_list_engine_top.sv
dv/indexed_linked_list_engine_top_tb.sv
